// ===== rtl/core/utf8v_pkg.sv =====
package utf8v_pkg;

    // Largest byte value that is plain ASCII
    localparam logic [7:0] ASCII_MAX = 8'h7F;

    // Allowed range of the next continuation byte
    localparam logic [2:0] CLS_80_BF = 3'd0;
    localparam logic [2:0] CLS_A0_BF = 3'd1;
    localparam logic [2:0] CLS_80_9F = 3'd2;
    localparam logic [2:0] CLS_90_BF = 3'd3;
    localparam logic [2:0] CLS_80_8F = 3'd4;

    // Per-string scan state
    typedef struct packed {
        logic [1:0] cont_left;
        logic [2:0] cls;
        logic       err;
        logic       ascii;
        logic       nul;
    } t_scan;

    // Result flags of one string
    typedef struct packed {
        logic well_formed;
        logic all_ascii;
        logic has_nul;
    } t_flags;

    localparam t_scan SCAN_RESET = '{
        cont_left: 2'd0,
        cls:       CLS_80_BF,
        err:       1'b0,
        ascii:     1'b1,
        nul:       1'b0
    };

endpackage

// ===== rtl/core/utf8v_step.sv =====
module utf8v_step (
    input  utf8v_pkg::t_scan  i_scan,
    input  logic [7:0]        i_data_byte,
    input  logic              i_byte_present,
    input  logic              i_end_of_string,
    output utf8v_pkg::t_scan  o_scan,
    output utf8v_pkg::t_flags o_flags
);
    import utf8v_pkg::*;

    t_scan      w_scan;
    logic [7:0] w_lo;
    logic [7:0] w_hi;

    // Bounds of the expected continuation byte
    always_comb begin
        w_lo = 8'h80;
        w_hi = 8'hBF;
        case (i_scan.cls)
            CLS_A0_BF: w_lo = 8'hA0;
            CLS_80_9F: w_hi = 8'h9F;
            CLS_90_BF: w_lo = 8'h90;
            CLS_80_8F: w_hi = 8'h8F;
            default:   ;
        endcase
    end

    // Examine the byte against the current scan state
    always_comb begin
        w_scan = i_scan;
        if (i_byte_present && !i_scan.err) begin
            if (i_scan.cont_left == 2'd0) begin
                if (i_data_byte == 8'h00) begin
                    w_scan.nul = 1'b1;
                end
                if (i_data_byte > ASCII_MAX) begin
                    w_scan.ascii = 1'b0;
                    case (i_data_byte) inside
                        [8'hC2:8'hDF]: begin
                            w_scan.cont_left = 2'd1;
                            w_scan.cls       = CLS_80_BF;
                        end
                        [8'hE0:8'hEF]: begin
                            w_scan.cont_left = 2'd2;
                            if (i_data_byte == 8'hE0) begin
                                w_scan.cls = CLS_A0_BF;
                            end else if (i_data_byte == 8'hED) begin
                                w_scan.cls = CLS_80_9F;
                            end else begin
                                w_scan.cls = CLS_80_BF;
                            end
                        end
                        [8'hF0:8'hF4]: begin
                            w_scan.cont_left = 2'd3;
                            if (i_data_byte == 8'hF0) begin
                                w_scan.cls = CLS_90_BF;
                            end else if (i_data_byte == 8'hF4) begin
                                w_scan.cls = CLS_80_8F;
                            end else begin
                                w_scan.cls = CLS_80_BF;
                            end
                        end
                        default: w_scan.err = 1'b1;
                    endcase
                end
            end else if (i_data_byte >= w_lo && i_data_byte <= w_hi) begin
                w_scan.cont_left = i_scan.cont_left - 2'd1;
                w_scan.cls       = CLS_80_BF;
            end else begin
                w_scan.err       = 1'b1;
                w_scan.cont_left = 2'd0;
                w_scan.cls       = CLS_80_BF;
            end
        end
    end

    // Flags at end of string; a pending sequence counts as an error
    assign o_flags.well_formed = !(w_scan.err || (w_scan.cont_left != 2'd0));
    assign o_flags.all_ascii   = w_scan.ascii;
    assign o_flags.has_nul     = w_scan.nul;

    // Restart the scan after the last beat of a string
    assign o_scan = i_end_of_string ? SCAN_RESET : w_scan;

endmodule

// ===== rtl/core/utf8_validate_flags_top.sv =====
// Channel | Direction | Handshake               | Payload
// input   | in        | i_in_valid / o_in_stall  | i_data_byte, i_byte_present, i_end_of_string
// result  | out       | o_out_valid / i_out_stall| o_well_formed, o_all_ascii, o_has_nul
//
// One beat per cycle while the input is not stalled; a result follows the beat that
// ends its string through the input register, then the result register.
// The per-byte check sits between the input register and the scan/result registers.
// Reset (i_rst_n low, synchronous) empties both registers and restarts the scan.
// A stalled result holds; the input stalls only while a full result is held and
// the waiting beat ends a string.
module utf8_validate_flags_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_well_formed,
    output logic       o_all_ascii,
    output logic       o_has_nul
);
    import utf8v_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_present;
    logic       r_in_eos;
    t_scan      r_scan;
    t_scan      n_scan;
    t_flags     n_flags;
    t_flags     r_flags;
    logic       r_out_valid;
    logic       w_fire;

    // Process the held beat unless it ends a string and the result slot is blocked
    assign w_fire     = r_in_valid && (!r_in_eos || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    // Capture the incoming beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte    <= i_data_byte;
            r_in_present <= i_byte_present;
            r_in_eos     <= i_end_of_string;
        end
    end

    utf8v_step u_step (
        .i_scan          (r_scan),
        .i_data_byte     (r_in_byte),
        .i_byte_present  (r_in_present),
        .i_end_of_string (r_in_eos),
        .o_scan          (n_scan),
        .o_flags         (n_flags)
    );

    // Advance the scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
        end else if (w_fire) begin
            r_scan <= n_scan;
        end
    end

    // Load a result at end of string, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_eos) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_eos) begin
            r_flags <= n_flags;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_well_formed = r_flags.well_formed;
    assign o_all_ascii   = r_flags.all_ascii;
    assign o_has_nul     = r_flags.has_nul;

endmodule

// ===== rtl/core/utf8v_checker.sv =====
module utf8v_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_well_formed,
    input logic       o_all_ascii,
    input logic       o_has_nul
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // Keep a stalled result payload stable
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            $stable(o_well_formed) && $stable(o_all_ascii) && $stable(o_has_nul))
        else $error("result payload changed while stalled");

    // Stall input only behind a blocked result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // An all-ASCII string is always well formed
    a_ascii_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_all_ascii |-> o_well_formed)
        else $error("all-ASCII string flagged malformed");

    // Leave reset empty
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("channel busy right after reset");

endmodule

bind utf8_validate_flags_top utf8v_checker u_utf8v_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
    import utf8v_pkg::*;

    typedef logic [7:0] t_octet_q[$];

    // Expected-flag tracker: mirrors the per-string scan and queues one flag set
    // for every beat that ends a string
    class utf8_scoreboard;
        t_flags     flags_q[$];
        logic [1:0] cont_left;
        logic [2:0] cls;
        logic       err;
        logic       ascii;
        logic       nul;
        int         errors;
        int         strings_checked;
        int         malformed_seen;
        int         beats_noted;

        function new();
            errors = 0;
            strings_checked = 0;
            malformed_seen = 0;
            beats_noted = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            cont_left = 2'd0;
            cls = CLS_80_BF;
            err = 1'b0;
            ascii = 1'b1;
            nul = 1'b0;
        endfunction

        function bit cont_in_range(logic [7:0] b);
            logic [7:0] lo;
            logic [7:0] hi;
            lo = 8'h80;
            hi = 8'hBF;
            case (cls)
                CLS_A0_BF: lo = 8'hA0;
                CLS_80_9F: hi = 8'h9F;
                CLS_90_BF: lo = 8'h90;
                CLS_80_8F: hi = 8'h8F;
                default:   ;
            endcase
            return (b >= lo) && (b <= hi);
        endfunction

        // Classify a byte that starts a new character
        function void scan_lead(logic [7:0] b);
            if (b == 8'h00)
                nul = 1'b1;
            if (b <= ASCII_MAX)
                return;
            ascii = 1'b0;
            if (b >= 8'hC2 && b <= 8'hDF) begin
                cont_left = 2'd1;
                cls = CLS_80_BF;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
                cont_left = 2'd2;
                cls = (b == 8'hE0) ? CLS_A0_BF : ((b == 8'hED) ? CLS_80_9F : CLS_80_BF);
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
                cont_left = 2'd3;
                cls = (b == 8'hF0) ? CLS_90_BF : ((b == 8'hF4) ? CLS_80_8F : CLS_80_BF);
            end else begin
                err = 1'b1;
            end
        endfunction

        // Advance the scan by one accepted input beat
        function void note_beat(logic [7:0] b, logic present, logic last);
            t_flags f;
            beats_noted++;
            if (present && !err) begin
                if (cont_left == 2'd0) begin
                    scan_lead(b);
                end else if (!cont_in_range(b)) begin
                    err = 1'b1;
                    cont_left = 2'd0;
                    cls = CLS_80_BF;
                end else begin
                    cont_left = cont_left - 2'd1;
                    cls = CLS_80_BF;
                end
            end
            if (last) begin
                if (cont_left != 2'd0)
                    err = 1'b1;
                f.well_formed = !err;
                f.all_ascii = ascii;
                f.has_nul = nul;
                flags_q.push_back(f);
                clear_scan();
            end
        endfunction

        // Compare one accepted result beat with the oldest expected flag set
        function void check_result(logic wf, logic aa, logic hn);
            t_flags f;
            if (flags_q.size() == 0) begin
                $display("%0t: result beat with none expected (wf=%0b ascii=%0b nul=%0b)",
                         $time, wf, aa, hn);
                errors++;
                return;
            end
            f = flags_q.pop_front();
            strings_checked++;
            if (!f.well_formed)
                malformed_seen++;
            if (wf !== f.well_formed) begin
                $display("%0t: well_formed expected %0b got %0b", $time, f.well_formed, wf);
                errors++;
            end
            if (aa !== f.all_ascii) begin
                $display("%0t: all_ascii expected %0b got %0b", $time, f.all_ascii, aa);
                errors++;
            end
            if (hn !== f.has_nul) begin
                $display("%0t: has_nul expected %0b got %0b", $time, f.has_nul, hn);
                errors++;
            end
        endfunction

        function int pending();
            return flags_q.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_string;
    logic       out_valid;
    logic       out_stall;
    logic       well_formed;
    logic       all_ascii;
    logic       has_nul;

    utf8_scoreboard sb;
    t_octet_q       str_q;
    int             items_sent = 0;
    int             noise_sent = 0;
    int             holds_done = 0;
    bit             noise_on = 1'b0;
    bit             sender_quiet = 1'b0;
    bit             long_hold_req = 1'b0;

    utf8_validate_flags_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_data_byte     (data_byte),
        .i_byte_present  (byte_present),
        .i_end_of_string (end_of_string),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_well_formed   (well_formed),
        .o_all_ascii     (all_ascii),
        .o_has_nul       (has_nul)
    );

    always #2 clk = ~clk;

    // Observe both channels on the edge that completes each beat
    always @(posedge clk) begin
        if (rst_n && in_valid && !in_stall)
            sb.note_beat(data_byte, byte_present, end_of_string);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(well_formed, all_ascii, has_nul);
    end

    // Drive one input beat and hold it until accepted
    task automatic send_beat(logic [7:0] b, logic present, logic last);
        in_valid <= 1'b1;
        data_byte <= b;
        byte_present <= present;
        end_of_string <= last;
        do @(posedge clk); while (in_stall);
        if (present || last)
            items_sent++;
        else
            noise_sent++;
    endtask

    task automatic idle_in(int n);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Mostly back-to-back, some short gaps, a few long ones
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (sender_quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Send str_q as one string; close it with a byte-less end beat when asked or when str_q is empty
    task automatic send_str(bit nobyte_end);
        int i;
        for (i = 0; i < str_q.size(); i++) begin
            if (noise_on && $urandom_range(0, 19) == 0) begin
                send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                idle_in(gap_cycles());
            end
            send_beat(str_q[i], 1'b1, (i == str_q.size() - 1) && !nobyte_end);
            idle_in(gap_cycles());
        end
        if (nobyte_end || str_q.size() == 0) begin
            send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            idle_in(gap_cycles());
        end
    endtask

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Append one well-formed character of random length
    function automatic void add_char();
        int kind;
        logic [7:0] lead;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            str_q.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 127)));
        end else if (kind < 6) begin
            str_q.push_back(8'($urandom_range(8'hC2, 8'hDF)));
            str_q.push_back(cont_byte());
        end else if (kind < 8) begin
            lead = 8'($urandom_range(8'hE0, 8'hEF));
            str_q.push_back(lead);
            if (lead == 8'hE0)
                str_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
            else if (lead == 8'hED)
                str_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
            else
                str_q.push_back(cont_byte());
            str_q.push_back(cont_byte());
        end else begin
            lead = 8'($urandom_range(8'hF0, 8'hF4));
            str_q.push_back(lead);
            if (lead == 8'hF0)
                str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
            else if (lead == 8'hF4)
                str_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
            else
                str_q.push_back(cont_byte());
            str_q.push_back(cont_byte());
            str_q.push_back(cont_byte());
        end
    endfunction

    // Damage str_q: cut it, corrupt a byte, add a stray byte, a forbidden form or a cut-short sequence
    function automatic void break_str();
        int k;
        int pos;
        k = $urandom_range(0, 4);
        pos = (str_q.size() > 0) ? $urandom_range(0, str_q.size() - 1) : 0;
        case (k)
            0: if (str_q.size() > 0) void'(str_q.pop_back());
            1: if (str_q.size() > 0) str_q[pos] = 8'($urandom_range(0, 255));
            2: str_q.insert(pos, 8'($urandom_range(8'h80, 8'hFF)));
            3: begin
                case ($urandom_range(0, 5))
                    0: begin
                        str_q.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                        str_q.push_back(cont_byte());
                    end
                    1: begin
                        str_q.push_back(8'hE0);
                        str_q.push_back(8'($urandom_range(8'h80, 8'h9F)));
                        str_q.push_back(cont_byte());
                    end
                    2: begin
                        str_q.push_back(8'hED);
                        str_q.push_back(8'($urandom_range(8'hA0, 8'hBF)));
                        str_q.push_back(cont_byte());
                    end
                    3: begin
                        str_q.push_back(8'hF4);
                        str_q.push_back(8'($urandom_range(8'h90, 8'hBF)));
                        str_q.push_back(cont_byte());
                        str_q.push_back(cont_byte());
                    end
                    4: begin
                        str_q.push_back(8'hF0);
                        str_q.push_back(8'($urandom_range(8'h80, 8'h8F)));
                        str_q.push_back(cont_byte());
                        str_q.push_back(cont_byte());
                    end
                    default: str_q.push_back(8'($urandom_range(8'hF5, 8'hFF)));
                endcase
            end
            default: begin
                str_q.push_back(8'($urandom_range(8'hE1, 8'hF3)));
                str_q.push_back(cont_byte());
            end
        endcase
        // Trailing bytes after the damage exercise the sticky error
        if (k != 0 && $urandom_range(0, 1) == 1)
            add_char();
    endfunction

    // Receiver: random stalls, quiet stretches, and the requested long holds
    initial begin
        int n;
        int r;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                holds_done++;
                out_stall <= 1'b1;
                n = 300;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 4);
                end else if (r < 55) begin
                    out_stall <= 1'b0;
                    n = $urandom_range(20, 80);
                end else if (r < 90) begin
                    out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end else begin
                    out_stall <= 1'b1;
                    n = $urandom_range(10, 40);
                end
            end
            repeat (n) @(posedge clk);
        end
    end

    // Main sequence: reset, directed strings, random strings, drain
    initial begin
        int nchars;
        int c;
        bit hold1_done;
        bit hold2_done;
        sb = new();
        hold1_done = 1'b0;
        hold2_done = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= 8'h00;
        byte_present <= 1'b0;
        end_of_string <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty string, zero byte, top ASCII byte, bad lead, stray continuation
        str_q = {};
        send_str(1'b0);
        str_q = '{8'h00};
        send_str(1'b0);
        str_q = '{8'h7F};
        send_str(1'b0);
        str_q = '{8'hFF};
        send_str(1'b0);
        str_q = '{8'h80};
        send_str(1'b0);
        // Byte-less beat that does not end a string
        send_beat(8'hA5, 1'b0, 1'b0);
        // Minimal two-byte form, then overlong
        str_q = '{8'hC2, 8'h80};
        send_str(1'b0);
        str_q = '{8'hC1, 8'hBF};
        send_str(1'b0);
        // Lowest valid after E0, surrogate, above the top code point
        str_q = '{8'hE0, 8'hA0, 8'h80};
        send_str(1'b0);
        str_q = '{8'hED, 8'hA0, 8'h80};
        send_str(1'b0);
        str_q = '{8'hF4, 8'h90, 8'h80, 8'h80};
        send_str(1'b0);
        // Cut short at the end, zero where a continuation belongs
        str_q = '{8'hE2, 8'h82};
        send_str(1'b0);
        str_q = '{8'hC2, 8'h00};
        send_str(1'b0);

        // Random strings, mostly well-formed with random content
        noise_on = 1'b1;
        while (items_sent < 1300) begin
            sender_quiet = ($urandom_range(0, 99) < 15);
            str_q = {};
            nchars = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            for (c = 0; c < nchars; c++)
                add_char();
            if ($urandom_range(0, 99) < 25)
                break_str();
            send_str($urandom_range(0, 7) == 0);
            if (!hold1_done && items_sent >= 450) begin
                hold1_done = 1'b1;
                long_hold_req = 1'b1;
            end
            if (!hold2_done && items_sent >= 1000) begin
                hold2_done = 1'b1;
                long_hold_req = 1'b1;
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Covered %0d strings (%0d malformed) from %0d beats, %0d byte-less fillers,",
                 sb.strings_checked, sb.malformed_seen, sb.beats_noted, noise_sent);
        $display("with random stalls on both sides and %0d long result holds.", holds_done);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog on the whole run
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/utf8v_pkg.sv
rtl/core/utf8v_step.sv
rtl/core/utf8_validate_flags_top.sv
rtl/core/utf8v_checker.sv
bench/tb_top.sv
